// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the complex-to-polar RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define C2P_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define C2P_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define C2P_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/c2p_pkg.sv =====
// Package for the complex-to-polar CORDIC: constants, angle table, control struct.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
package c2p_pkg;

    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int ROTATION_STAGES_DEF = 16;
    localparam int GUARD_BITS          = 8;
    localparam int ANGLE_W             = 32;
    localparam int MAX_STAGES          = 32;

    // Reciprocal CORDIC gain for infinitely many stages, scaled by 2^32.
    localparam logic [63:0] KINF_Q32 = 64'd2608131496;

    // atan(2^-i)/pi * 2^31, rounded to nearest.
    localparam logic [ANGLE_W-1:0] ATAN_TABLE [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Control bits that travel with each request down the pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
    } c2p_ctrl_t;

endpackage

// ===== hw/rtl/c2p_if.sv =====
// Stream interfaces of the complex-to-polar block: samples in, polar results out.
// Depends on c2p_pkg for the default sample width.
interface c2p_sample_if
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;

    modport source (output valid, output re, output im, input ready);
    modport sink   (input valid, input re, input im, output ready);
endinterface

interface c2p_polar_if
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic        [SAMPLE_WIDTH-1:0] magnitude;
    logic signed [SAMPLE_WIDTH-1:0] phase;

    modport source (output valid, output magnitude, output phase, input ready);
    modport sink   (input valid, input magnitude, input phase, output ready);
endinterface

// ===== hw/rtl/c2p_fold.sv =====
// Entry stage: folds the sample into the right half plane and scales it up.
// Depends on c2p_pkg.
module c2p_fold
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int DW           = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           valid,
    input  logic signed [SAMPLE_WIDTH-1:0] re,
    input  logic signed [SAMPLE_WIDTH-1:0] im,
    output c2p_ctrl_t                      ctrl,
    output logic signed [DW-1:0]           x,
    output logic signed [DW-1:0]           y,
    output logic        [ANGLE_W-1:0]      z
);
    c2p_ctrl_t              ctrl_reg, ctrl_next;
    logic signed [DW-1:0]   x_reg, x_next;
    logic signed [DW-1:0]   y_reg, y_next;
    logic [ANGLE_W-1:0]     z_reg, z_next;
    logic signed [DW-1:0]   re_ext;
    logic signed [DW-1:0]   im_ext;

    // A negative real part negates both parts and preloads the angle with pi.
    always_comb
    begin
        re_ext          = DW'(re);
        im_ext          = DW'(im);
        ctrl_next.valid = valid;
        ctrl_next.zero  = (re == '0) && (im == '0);
        if (re[SAMPLE_WIDTH-1])
        begin
            x_next = (-re_ext) <<< GUARD_BITS;
            y_next = (-im_ext) <<< GUARD_BITS;
            z_next = {1'b1, {(ANGLE_W-1){1'b0}}};
        end
        else
        begin
            x_next = re_ext <<< GUARD_BITS;
            y_next = im_ext <<< GUARD_BITS;
            z_next = '0;
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctrl = ctrl_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
endmodule

// ===== hw/rtl/c2p_rotator.sv =====
// One CORDIC micro-rotation in vectoring mode, registered.
// Depends on c2p_pkg and assert_macros.svh.
`include "assert_macros.svh"

module c2p_rotator
    import c2p_pkg::*;
#(
    parameter int DW    = SAMPLE_WIDTH_DEF + GUARD_BITS + 3,
    parameter int SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  c2p_ctrl_t            ctrl_in,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  logic [ANGLE_W-1:0]   z_in,
    output c2p_ctrl_t            ctrl_out,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output logic [ANGLE_W-1:0]   z_out
);
    localparam logic [ANGLE_W-1:0] ANGLE_STEP = ATAN_TABLE[SHIFT];

    c2p_ctrl_t              ctrl_reg;
    logic signed [DW-1:0]   x_reg, x_next;
    logic signed [DW-1:0]   y_reg, y_next;
    logic [ANGLE_W-1:0]     z_reg, z_next;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;

    // Rotate towards the real axis; the sign of y picks the direction.
    always_comb
    begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!y_in[DW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE_STEP;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE_STEP;
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

    // The real part starts non-negative after folding and only grows.
    `C2P_ASSERT_IMPLIES(a_x_nonneg, clk, rst_n, ctrl_reg.valid, !x_reg[DW-1], "rotator x negative")
endmodule

// ===== hw/rtl/c2p_scale.sv =====
// Back end: gain compensation of the magnitude and rounding of both results.
// Depends on c2p_pkg and assert_macros.svh.
`include "assert_macros.svh"

module c2p_scale
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int ROTATION_STAGES = ROTATION_STAGES_DEF,
    parameter int DW              = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  c2p_ctrl_t                      ctrl_in,
    input  logic signed [DW-1:0]           x_in,
    input  logic [ANGLE_W-1:0]             z_in,
    output c2p_ctrl_t                      ctrl_out,
    output logic [SAMPLE_WIDTH-1:0]        magnitude,
    output logic signed [SAMPLE_WIDTH-1:0] phase
);
    localparam int HW  = DW - 16;
    localparam int PHW = HW + 32;
    localparam int MW  = DW + 1;
    localparam int GAIN_SHIFT = (ROTATION_STAGES >= 20) ? 0 : 2 * ROTATION_STAGES;
    localparam logic [63:0] GAIN_FULL = (ROTATION_STAGES >= 20) ? KINF_Q32 :
        KINF_Q32 + (64'd2 * KINF_Q32) / (64'd3 << GAIN_SHIFT);
    localparam logic [31:0] GAIN = GAIN_FULL[31:0];
    localparam logic [MW:0] ROUND_HALF = (MW+1)'(1) << (GUARD_BITS - 1);

    c2p_ctrl_t                ctrl_s1_reg, ctrl_s2_reg, ctrl_s3_reg;
    logic [PHW-1:0]           p_hi_reg, p_hi_next;
    logic [47:0]              p_lo_reg, p_lo_next;
    logic [ANGLE_W-1:0]       z_s1_reg, z_s2_reg;
    logic [MW-1:0]            mag_raw_reg, mag_raw_next;
    logic [SAMPLE_WIDTH-1:0]  mag_reg, mag_next;
    logic [SAMPLE_WIDTH-1:0]  phase_reg, phase_next;
    logic [PHW:0]             prod;
    logic [MW:0]              mag_rnd;
    logic [SAMPLE_WIDTH-1:0]  phase_rnd;

    // First stage: the two partial products of x times the gain.
    always_comb
    begin
        p_hi_next = PHW'(x_in[DW-1:16]) * PHW'(GAIN);
        p_lo_next = 48'(x_in[15:0]) * 48'(GAIN);
    end

    // Second stage: sum the partial products and drop 32 fraction bits.
    always_comb
    begin
        prod         = {1'b0, p_hi_reg} + (PHW+1)'(p_lo_reg[47:16]);
        mag_raw_next = prod[PHW:16];
    end

    // Phase rounds half up to its top bits and wraps.
    generate
        if (SAMPLE_WIDTH >= ANGLE_W)
        begin : g_phase_full
            assign phase_rnd = SAMPLE_WIDTH'(z_s2_reg);
        end
        else
        begin : g_phase_round
            logic [ANGLE_W-1:0] z_rnd;
            assign z_rnd     = z_s2_reg + (ANGLE_W'(1) << (ANGLE_W - 1 - SAMPLE_WIDTH));
            assign phase_rnd = z_rnd[ANGLE_W-1 -: SAMPLE_WIDTH];
        end
    endgenerate

    // Third stage: drop the guard bits with rounding, saturate, force zero input.
    always_comb
    begin
        mag_rnd = {1'b0, mag_raw_reg} + ROUND_HALF;
        if (mag_rnd[MW:GUARD_BITS+SAMPLE_WIDTH] != '0)
        begin
            mag_next = '1;
        end
        else
        begin
            mag_next = mag_rnd[GUARD_BITS+SAMPLE_WIDTH-1:GUARD_BITS];
        end
        phase_next = ctrl_s2_reg.zero ? '0 : phase_rnd;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_s1_reg <= '0;
            ctrl_s2_reg <= '0;
            ctrl_s3_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_s1_reg <= ctrl_in;
            ctrl_s2_reg <= ctrl_s1_reg;
            ctrl_s3_reg <= ctrl_s2_reg;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_hi_reg    <= p_hi_next;
            p_lo_reg    <= p_lo_next;
            z_s1_reg    <= z_in;
            mag_raw_reg <= mag_raw_next;
            z_s2_reg    <= z_s1_reg;
            mag_reg     <= mag_next;
            phase_reg   <= phase_next;
        end
    end

    assign ctrl_out  = ctrl_s3_reg;
    assign magnitude = mag_reg;
    assign phase     = phase_reg;

    // A zero sample must leave the back end as zero magnitude and zero phase.
    `C2P_ASSERT_IMPLIES(a_zero_result, clk, rst_n, ctrl_s3_reg.valid && ctrl_s3_reg.zero, (mag_reg == '0) && (phase_reg == '0), "zero sample gave non-zero result")
endmodule

// ===== hw/rtl/c2p_skid.sv =====
// Output buffer: output register plus skid register, so the pipeline never sees
// the receiver's ready combinationally. Depends on c2p_pkg, c2p_if and assert_macros.svh.
`include "assert_macros.svh"

module c2p_skid
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    input  logic [SAMPLE_WIDTH-1:0]        up_magnitude,
    input  logic signed [SAMPLE_WIDTH-1:0] up_phase,
    output logic                           up_ready,
    c2p_polar_if.source                    polar
);
    logic                           out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]        out_mag_reg, out_mag_next;
    logic signed [SAMPLE_WIDTH-1:0] out_phase_reg, out_phase_next;
    logic                           skid_valid_reg, skid_valid_next;
    logic [SAMPLE_WIDTH-1:0]        skid_mag_reg, skid_mag_next;
    logic signed [SAMPLE_WIDTH-1:0] skid_phase_reg, skid_phase_next;
    logic                           up_fire;
    logic                           out_free;

    assign up_ready = !skid_valid_reg;
    assign up_fire  = up_valid && up_ready;
    assign out_free = !out_valid_reg || polar.ready;

    // The output register refills from the skid register first, then from upstream.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_mag_next    = out_mag_reg;
        out_phase_next  = out_phase_reg;
        skid_valid_next = skid_valid_reg;
        skid_mag_next   = skid_mag_reg;
        skid_phase_next = skid_phase_reg;
        if (out_free)
        begin
            skid_valid_next = 1'b0;
            if (skid_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_mag_next   = skid_mag_reg;
                out_phase_next = skid_phase_reg;
            end
            else
            begin
                out_valid_next = up_fire;
                out_mag_next   = up_magnitude;
                out_phase_next = up_phase;
            end
        end
        else if (up_fire)
        begin
            skid_valid_next = 1'b1;
            skid_mag_next   = up_magnitude;
            skid_phase_next = up_phase;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        out_mag_reg    <= out_mag_next;
        out_phase_reg  <= out_phase_next;
        skid_mag_reg   <= skid_mag_next;
        skid_phase_reg <= skid_phase_next;
    end

    assign polar.valid     = out_valid_reg;
    assign polar.magnitude = out_mag_reg;
    assign polar.phase     = out_phase_reg;

    // The skid register only ever holds a request behind a full output register.
    `C2P_ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full while output empty")
    // The skid register fills only when the output register was stalled.
    `C2P_ASSERT_IMPLIES(a_skid_fill, clk, rst_n, $rose(skid_valid_reg), $past(out_valid_reg && !polar.ready), "skid filled without a stall")
endmodule

// ===== hw/rtl/complex_to_polar_unit.sv =====
// Complex-to-polar converter: CORDIC vectoring pipeline giving magnitude and phase.
// Depends on c2p_pkg, c2p_if, c2p_fold, c2p_rotator, c2p_scale and c2p_skid.
//
// Usage:
//   sample (sink): one complex request per accepted cycle, re and im in signed
//   fixed point. Accepted at a rising edge where sample.valid and sample.ready are high.
//   polar (source): magnitude (unsigned, input scale) and phase (two's complement,
//   half the range stands for pi; +pi wraps to the most negative code).
//   Pipeline: from acceptance to polar.valid a request passes one fold stage, one
//   register per micro-rotation, three back-end stages and the output register.
//   Throughput: one request per cycle, sustained, as long as polar.ready stays high;
//   each micro-rotation and each multiply has its own stage.
//   Stall: when the receiver holds polar.ready low, one further result lands in the
//   skid register, then the whole pipeline freezes and sample.ready falls. Nothing
//   is lost or repeated; sample.ready depends only on registered state.
//   Reset: rst_n clears all valid bits at once; the block is ready as soon as
//   reset is released. The block keeps no state between requests.
module complex_to_polar_unit
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    c2p_sample_if.sink  sample,
    c2p_polar_if.source polar
);
    localparam int DW = SAMPLE_WIDTH + GUARD_BITS + 3;

    logic                           advance;
    c2p_ctrl_t                      rot_ctrl [ROTATION_STAGES+1];
    logic signed [DW-1:0]           rot_x    [ROTATION_STAGES+1];
    logic signed [DW-1:0]           rot_y    [ROTATION_STAGES+1];
    logic [ANGLE_W-1:0]             rot_z    [ROTATION_STAGES+1];
    c2p_ctrl_t                      back_ctrl;
    logic [SAMPLE_WIDTH-1:0]        back_mag;
    logic signed [SAMPLE_WIDTH-1:0] back_phase;

    // The whole pipeline moves while the skid register has room.
    assign sample.ready = advance;

    c2p_fold #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DW           (DW)
    ) u_fold (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .valid   (sample.valid),
        .re      (sample.re),
        .im      (sample.im),
        .ctrl    (rot_ctrl[0]),
        .x       (rot_x[0]),
        .y       (rot_y[0]),
        .z       (rot_z[0])
    );

    // One registered micro-rotation per stage.
    generate
        for (genvar i = 0; i < ROTATION_STAGES; i++)
        begin : g_rot
            c2p_rotator #(
                .DW    (DW),
                .SHIFT (i)
            ) u_rot (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .ctrl_in  (rot_ctrl[i]),
                .x_in     (rot_x[i]),
                .y_in     (rot_y[i]),
                .z_in     (rot_z[i]),
                .ctrl_out (rot_ctrl[i+1]),
                .x_out    (rot_x[i+1]),
                .y_out    (rot_y[i+1]),
                .z_out    (rot_z[i+1])
            );
        end
    endgenerate

    c2p_scale #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .ROTATION_STAGES (ROTATION_STAGES),
        .DW              (DW)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctrl_in   (rot_ctrl[ROTATION_STAGES]),
        .x_in      (rot_x[ROTATION_STAGES]),
        .z_in      (rot_z[ROTATION_STAGES]),
        .ctrl_out  (back_ctrl),
        .magnitude (back_mag),
        .phase     (back_phase)
    );

    c2p_skid #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (back_ctrl.valid),
        .up_magnitude (back_mag),
        .up_phase     (back_phase),
        .up_ready     (advance),
        .polar        (polar)
    );
endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for complex_to_polar_unit: directed and random complex samples
// against a bit-exact CORDIC vectoring model. Depends on c2p_pkg, c2p_if and the RTL.
`timescale 1ns / 1ps

module tb_top
    import c2p_pkg::*;
();

    localparam int SW         = SAMPLE_WIDTH_DEF;
    localparam int STAGES     = ROTATION_STAGES_DEF;
    localparam int RUN_STAGES = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
    localparam int RANDOM_N   = 600;
    localparam int REPORT_MAX = 10;
    localparam int DRAIN_CYC  = 2 * (STAGES + 4);

    typedef struct {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
    } sample_t;

    typedef struct {
        logic        [SW-1:0] magnitude;
        logic signed [SW-1:0] phase;
    } polar_t;

    logic clk;
    logic rst_n;

    c2p_sample_if #(.SAMPLE_WIDTH(SW)) sample_bus ();
    c2p_polar_if  #(.SAMPLE_WIDTH(SW)) polar_bus ();

    complex_to_polar_unit #(
        .SAMPLE_WIDTH   (SW),
        .ROTATION_STAGES(STAGES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_bus),
        .polar (polar_bus)
    );

    sample_t     pending_samples[$];
    polar_t      polar_expected[$];
    sample_t     next_sample;
    sample_t     seen_sample;
    polar_t      got_polar;
    polar_t      want_polar;
    int unsigned cyc;
    int unsigned accepted_n;
    int unsigned total_n;
    int unsigned mismatch_n;
    int unsigned hold_left;
    bit          hold_done;
    bit          req_taken;

    // Bit-exact magnitude and phase of one sample.
    function automatic polar_t to_polar(sample_t s);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        logic [63:0] gain;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] prod;
        logic [63:0] mag;
        logic [63:0] ph;
        logic [63:0] mask;
        int          i;
        polar_t      r;
        x = longint'(s.re);
        y = longint'(s.im);
        z = '0;
        mask = (64'd1 << SW) - 64'd1;
        if (x == 0 && y == 0)
        begin
            r.magnitude = '0;
            r.phase     = '0;
            return r;
        end
        // Fold into the right half plane, starting the angle at pi.
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        x = x <<< GUARD_BITS;
        y = y <<< GUARD_BITS;
        for (i = 0; i < RUN_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TABLE[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TABLE[i];
            end
        end
        // Gain compensation in two halves so that the product stays in 64 bits.
        if (RUN_STAGES >= 20)
            gain = KINF_Q32;
        else
            gain = KINF_Q32 + (64'd2 * KINF_Q32) / (64'd3 << (2 * RUN_STAGES));
        hi   = x;
        hi   = hi >> 16;
        lo   = x;
        lo   = lo & 64'hFFFF;
        prod = hi * gain + ((lo * gain) >> 16);
        mag  = prod >> 16;
        mag  = (mag + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
        if (mag > mask)
            mag = mask;
        if (SW >= 32)
            ph = {32'd0, z};
        else
            ph = ({32'd0, z} + (64'd1 << (31 - SW))) >> (32 - SW);
        r.magnitude = mag[SW-1:0];
        r.phase     = ph[SW-1:0];
        return r;
    endfunction

    // Queue one sample for the driver.
    task automatic add_sample(input logic [SW-1:0] re, input logic [SW-1:0] im);
        sample_t s;
        s.re = re;
        s.im = im;
        pending_samples.push_back(s);
    endtask

    // Random idling, switched off during a quiet window in the middle of the run.
    function automatic bit idle_now();
        if (cyc >= 400 && cyc < 700)
            return 1'b0;
        return $urandom_range(99) < 13;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_n++;
        if (mismatch_n <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s", cyc, what);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Cycle count and the long receiver hold-off that backs the pipeline up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc       <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (!hold_done && accepted_n >= 60)
            begin
                hold_left <= 80;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // Driver: holds each request until it is taken, then offers the next or idles.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_bus.valid <= 1'b0;
            sample_bus.re    <= '0;
            sample_bus.im    <= '0;
        end
        else if (!sample_bus.valid || req_taken)
        begin
            if (pending_samples.size() != 0 && !idle_now())
            begin
                next_sample = pending_samples.pop_front();
                sample_bus.valid <= 1'b1;
                sample_bus.re    <= next_sample.re;
                sample_bus.im    <= next_sample.im;
            end
            else
                sample_bus.valid <= 1'b0;
        end
    end

    // Receiver readiness.
    always @(negedge clk)
    begin
        if (!rst_n)
            polar_bus.ready <= 1'b0;
        else
            polar_bus.ready <= (hold_left == 0) && !idle_now();
    end

    // Monitor: records accepted requests and checks each result against the oldest
    // expected one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= sample_bus.valid && sample_bus.ready;
            if (polar_bus.valid && polar_bus.ready)
            begin
                got_polar.magnitude = polar_bus.magnitude;
                got_polar.phase     = polar_bus.phase;
                if (polar_expected.size() == 0)
                    note_mismatch($sformatf("unexpected result magnitude %0d phase %0d",
                                            got_polar.magnitude, got_polar.phase));
                else
                begin
                    want_polar = polar_expected.pop_front();
                    if (got_polar.magnitude !== want_polar.magnitude)
                        note_mismatch($sformatf("magnitude expected %0d actual %0d",
                                                want_polar.magnitude, got_polar.magnitude));
                    if (got_polar.phase !== want_polar.phase)
                        note_mismatch($sformatf("phase expected %0d actual %0d",
                                                want_polar.phase, got_polar.phase));
                end
            end
            if (sample_bus.valid && sample_bus.ready)
            begin
                seen_sample.re = sample_bus.re;
                seen_sample.im = sample_bus.im;
                polar_expected.push_back(to_polar(seen_sample));
                accepted_n <= accepted_n + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int          n;
        int unsigned pick;
        logic [SW-1:0] a;
        logic [SW-1:0] b;
        rst_n = 1'b0;

        // Directed requests: zero, the axes, the corners and the negative real axis.
        add_sample(16'sd0, 16'sd0);
        add_sample(16'sd32767, 16'sd0);
        add_sample(-16'sd32768, 16'sd0);
        add_sample(-16'sd1, 16'sd0);
        add_sample(16'sd0, 16'sd32767);
        add_sample(16'sd0, -16'sd32768);
        add_sample(16'sd32767, 16'sd32767);
        add_sample(-16'sd32768, -16'sd32768);
        add_sample(-16'sd32768, 16'sd32767);
        add_sample(16'sd32767, -16'sd32768);
        add_sample(16'sd1, 16'sd0);
        add_sample(16'sd0, 16'sd1);
        add_sample(16'sd0, -16'sd1);
        add_sample(-16'sd1, -16'sd1);
        add_sample(-16'sd1, 16'sd1);
        add_sample(-16'sd32768, 16'sd1);
        add_sample(-16'sd32768, -16'sd1);
        add_sample(16'sd5, -16'sd3);
        add_sample(16'h5555, 16'hAAAA);
        add_sample(16'hAAAA, 16'h5555);
        add_sample(16'sd23170, 16'sd23170);
        add_sample(-16'sd23170, 16'sd23170);

        // Random requests: half full range, with small values, axes, diagonals
        // and near-extreme values mixed in.
        for (n = 0; n < RANDOM_N; n++)
        begin
            pick = $urandom_range(99);
            a    = SW'($urandom);
            b    = SW'($urandom);
            if (pick < 50)
                add_sample(a, b);
            else if (pick < 70)
                add_sample(16'($urandom_range(128)) - 16'd64,
                           16'($urandom_range(128)) - 16'd64);
            else if (pick < 78)
                add_sample(a, '0);
            else if (pick < 85)
                add_sample('0, b);
            else if (pick < 92)
                add_sample(a, ($urandom_range(1) != 0) ? a : -a);
            else
                add_sample(($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF,
                           16'($urandom_range(16)) - 16'd8);
        end
        total_n = pending_samples.size();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_n < total_n)
            @(posedge clk);
        while (polar_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatch_n == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
